// File: sv/lpde_pkg.sv
package lpde_pkg;

  // fixed-point layout of the ports
  localparam int FRAC_BITS = 16;
  localparam int PW        = FRAC_BITS + 2;   // x and P, signed Q1.F
  localparam int DW        = FRAC_BITS + 10;  // P', signed Q9.F
  localparam int MW        = 2 * PW;          // products before rounding
  localparam int DGW       = 5;               // degree field and degree_max register
  localparam int AW        = 3;               // config byte address

  localparam int MAX_DEGREE_DEF = 31;

  // config register indexes
  localparam logic REG_DEGREE_MAX = 1'b0;

  localparam logic [DGW-1:0] DEGREE_MAX_RST = DGW'(8);

  localparam logic signed [PW-1:0]   ONE_FX    = PW'(2 ** FRAC_BITS);
  localparam logic signed [MW-1:0]   ONE_MW    = MW'(ONE_FX);
  localparam logic signed [MW-1:0]   HALF_MW   = MW'(2 ** (FRAC_BITS - 1));
  localparam logic signed [DW-1:0]   DERIV_LIM = DW'(496 * (2 ** FRAC_BITS));
  localparam logic signed [DW:0]     DLIM_X    = (DW + 1)'(DERIV_LIM);

  // recurrence state handed from one cell to the next
  typedef struct packed {
    logic                 vld;
    logic                 last;
    logic signed [PW-1:0] x;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [DW-1:0] d1;
    logic signed [DW-1:0] d2;
  } chain_t;

  // one result item
  typedef struct packed {
    logic                 vld;
    logic [DGW-1:0]       degree;
    logic signed [PW-1:0] poly;
    logic signed [DW-1:0] deriv;
    logic                 last;
  } res_t;

endpackage

// File: sv/lpde_cell.sv
module lpde_cell
  import lpde_pkg::*;
#(
  parameter int unsigned K = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic [DGW-1:0] top,
  input  chain_t         chain_i,
  output chain_t         chain_o,
  output res_t           res_o
);

  // round-half-up Q.F coefficients of the recurrence for degree K
  localparam int A_I = ((2 * K - 1) * (2 ** (FRAC_BITS + 1)) + K) / (2 * K);
  localparam int B_I = ((K - 1) * (2 ** (FRAC_BITS + 1)) + K) / (2 * K);
  localparam logic signed [PW-1:0] A_C = PW'(A_I);
  localparam logic signed [PW-1:0] B_C = PW'(B_I);
  localparam logic signed [PW-1:0] D_C = PW'(2 * K - 1);
  localparam logic [DGW-1:0]       DEG = DGW'(K);

  logic take;

  logic                 s1_vld_r, s1_last_r;
  logic signed [PW-1:0] s1_x_r, s1_p1_r;
  logic signed [DW-1:0] s1_d1_r, s1_d_r;
  logic signed [MW-1:0] s1_xp_r, s1_pb_r;
  logic signed [MW-1:0] s1_xp_nxt, s1_pb_nxt;
  logic signed [DW:0]   dsum;
  logic signed [DW-1:0] s1_d_nxt;

  logic                 s2_vld_r, s2_last_r;
  logic signed [PW-1:0] s2_x_r, s2_p1_r;
  logic signed [DW-1:0] s2_d1_r, s2_d_r;
  logic signed [MW-1:0] s2_at_r, s2_pb_r;
  logic signed [MW-1:0] t_full, s2_at_nxt;
  logic signed [PW-1:0] t_val;

  logic                 s3_vld_r, s3_last_r;
  logic signed [PW-1:0] s3_x_r, s3_p2_r, s3_p_r;
  logic signed [DW-1:0] s3_d2_r, s3_d_r;
  logic signed [MW-1:0] diff, r_full;
  logic signed [PW-1:0] s3_p_nxt;

  // tokens past the configured degree die here
  assign take = chain_i.vld && (32'(top) >= K);

  // stage 1: x*P(i-1), B*P(i-2) and the derivative
  always_comb begin
    s1_xp_nxt = chain_i.x * chain_i.p1;
    s1_pb_nxt = B_C * chain_i.p2;
    dsum      = D_C * chain_i.p1 + chain_i.d2;
    if (dsum > DLIM_X) begin
      s1_d_nxt = DERIV_LIM;
    end else if (dsum < -DLIM_X) begin
      s1_d_nxt = -DERIV_LIM;
    end else begin
      s1_d_nxt = dsum[DW-1:0];
    end
  end

  // stage 2: round t, then A*t
  always_comb begin
    t_full    = (s1_xp_r + HALF_MW) >>> FRAC_BITS;
    t_val     = t_full[PW-1:0];
    s2_at_nxt = A_C * t_val;
  end

  // stage 3: difference, round, saturate
  always_comb begin
    diff   = s2_at_r - s2_pb_r;
    r_full = (diff + HALF_MW) >>> FRAC_BITS;
    if (r_full > ONE_MW) begin
      s3_p_nxt = ONE_FX;
    end else if (r_full < -ONE_MW) begin
      s3_p_nxt = -ONE_FX;
    end else begin
      s3_p_nxt = r_full[PW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= take;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_last_r <= (32'(top) == K);
      s1_x_r    <= chain_i.x;
      s1_p1_r   <= chain_i.p1;
      s1_d1_r   <= chain_i.d1;
      s1_xp_r   <= s1_xp_nxt;
      s1_pb_r   <= s1_pb_nxt;
      s1_d_r    <= s1_d_nxt;

      s2_last_r <= s1_last_r;
      s2_x_r    <= s1_x_r;
      s2_p1_r   <= s1_p1_r;
      s2_d1_r   <= s1_d1_r;
      s2_d_r    <= s1_d_r;
      s2_pb_r   <= s1_pb_r;
      s2_at_r   <= s2_at_nxt;

      s3_last_r <= s2_last_r;
      s3_x_r    <= s2_x_r;
      s3_p2_r   <= s2_p1_r;
      s3_d2_r   <= s2_d1_r;
      s3_d_r    <= s2_d_r;
      s3_p_r    <= s3_p_nxt;
    end
  end

  assign chain_o = '{vld: s3_vld_r, last: s3_last_r, x: s3_x_r, p1: s3_p_r, p2: s3_p2_r,
                     d1: s3_d_r, d2: s3_d2_r};

  assign res_o = '{vld: s3_vld_r, degree: DEG, poly: s3_p_r, deriv: s3_d_r,
                   last: s3_last_r};

endmodule

// File: sv/legendre_poly_and_deriv_eval_core.sv
// degree 0 passes the degree 0 slot and the output register, degree 1 also the
//   degree 1 slot, degree i (i >= 2) also the three-stage multiply cells for 2 to i
// one item in the row at a time: the next is taken once the last result of the
//   one before, degree top = min(degree_max, MAX_DEGREE), enters the output register
// stalls on the output freeze the whole cell row, nothing is dropped
// reset: synchronous, active low; degree_max returns to 8, all valid bits clear
module legendre_poly_and_deriv_eval_core
  import lpde_pkg::*;
#(
  parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [PW-1:0] in_x_value,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DGW-1:0]       out_degree,
  output logic signed [PW-1:0] out_poly_value,
  output logic signed [DW-1:0] out_deriv_value,
  output logic                 out_last,
  // config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AW-1:0]        paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  // one cell for each degree from 2 to MAX_DEGREE
  localparam int NCELL = MAX_DEGREE - 1;
  localparam int NSRC  = NCELL + 2;

  logic [DGW-1:0] degree_max_r;
  logic [DGW-1:0] top;

  logic adv;       // whole row moves forward this cycle
  logic accept;
  logic busy_r;

  // front: degree 0 slot then degree 1 slot
  logic                 f0_vld_r, f1_vld_r;
  logic signed [PW-1:0] f0_x_r, f1_x_r;
  logic signed [PW-1:0] x_sat;

  chain_t chain [NCELL+1];
  res_t   src   [NSRC];
  res_t   sel;

  logic                 out_valid_r;
  logic [DGW-1:0]       out_degree_r;
  logic signed [PW-1:0] out_poly_r;
  logic signed [DW-1:0] out_deriv_r;
  logic                 out_last_r;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_max_r <= DEGREE_MAX_RST;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_DEGREE_MAX)) begin
      degree_max_r <= pwdata[DGW-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_DEGREE_MAX) ? {{(32-DGW){1'b0}}, degree_max_r} : '0;

  // highest degree emitted, clipped to MAX_DEGREE
  assign top = (32'(degree_max_r) > MAX_DEGREE) ? DGW'(MAX_DEGREE) : degree_max_r;

  // ---------------------------------------------------------------- handshake
  // the output register is free or being emptied
  assign adv      = !out_valid_r || !out_stall;
  // one point in the row at a time; chain tail only shows while busy anyway
  assign in_stall = busy_r || !adv || chain[NCELL].vld;
  assign accept   = in_valid && !in_stall;

  // points outside minus one to one are clipped first
  always_comb begin
    if (in_x_value > ONE_FX) begin
      x_sat = ONE_FX;
    end else if (in_x_value < -ONE_FX) begin
      x_sat = -ONE_FX;
    end else begin
      x_sat = in_x_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f0_vld_r <= 1'b0;
      f1_vld_r <= 1'b0;
    end else if (adv) begin
      f0_vld_r <= accept;
      f1_vld_r <= f0_vld_r && (top != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (accept) begin
        f0_x_r <= x_sat;
      end
      f1_x_r <= f0_x_r;
    end
  end

  // busy from the accept until the last result enters the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (accept) begin
      busy_r <= 1'b1;
    end else if (adv && sel.vld && sel.last) begin
      busy_r <= 1'b0;
    end
  end

  // ---------------------------------------------------------------- cell row
  // degree 1 seeds the recurrence: P1 = x, P0 = 1, P'1 = 1, P'0 = 0
  assign chain[0] = '{vld: f1_vld_r, last: 1'b0, x: f1_x_r, p1: f1_x_r, p2: ONE_FX,
                      d1: DW'(ONE_FX), d2: '0};

  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    lpde_cell #(
      .K (g + 2)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .top     (top),
      .chain_i (chain[g]),
      .chain_o (chain[g+1]),
      .res_o   (src[g+2])
    );
  end

  assign src[0] = '{vld: f0_vld_r, degree: '0, poly: ONE_FX, deriv: '0,
                    last: (top == '0)};
  assign src[1] = '{vld: f1_vld_r, degree: DGW'(1), poly: f1_x_r, deriv: DW'(ONE_FX),
                    last: (top == DGW'(1))};

  // result slots are spaced apart, at most one source is valid per cycle
  always_comb begin
    sel = '0;
    for (int i = 0; i < NSRC; i++) begin
      if (src[i].vld) begin
        sel = sel | src[i];
      end
    end
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sel.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && sel.vld) begin
      out_degree_r <= sel.degree;
      out_poly_r   <= sel.poly;
      out_deriv_r  <= sel.deriv;
      out_last_r   <= sel.last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_degree      = out_degree_r;
  assign out_poly_value  = out_poly_r;
  assign out_deriv_value = out_deriv_r;
  assign out_last        = out_last_r;

endmodule

// File: sv/lpde_chk.sv
module lpde_chk
  import lpde_pkg::*;
(
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [DGW-1:0]       out_degree,
  input logic signed [PW-1:0] out_poly_value,
  input logic signed [DW-1:0] out_deriv_value,
  input logic                 out_last
);

  logic [DGW-1:0] exp_deg_r;
  logic [DGW-1:0] exp_deg_nxt;

  // degree expected on the next result
  always_comb begin
    exp_deg_nxt = exp_deg_r;
    if (out_valid && !out_stall) begin
      exp_deg_nxt = out_last ? '0 : out_degree + DGW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_deg_r <= '0;
    end else begin
      exp_deg_r <= exp_deg_nxt;
    end
  end

  // one point at a time
  a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second point taken right after a point");

  // degree 0 shows once the point has passed the degree 0 slot and the output register
  a_first_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |-> ##2 (out_valid && out_degree == '0))
    else $error("degree 0 result late");

  // degrees run up by one and restart after last
  a_degree_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_degree == exp_deg_r)
    else $error("result degree out of order");

  // degree 0 is the constant polynomial
  a_degree_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degree == '0 |-> out_poly_value == ONE_FX && out_deriv_value == '0)
    else $error("degree 0 result wrong");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_degree) && $stable(out_poly_value)
      && $stable(out_deriv_value) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind legendre_poly_and_deriv_eval_core lpde_chk u_lpde_chk (.*);
